/* rtl/core/drs_pkg.sv */
// ----------------------------------------------------------------------------
// drs_pkg: shared types and constants for the disk request scheduler
// Holds the item structs, the queue entry type and the queue geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package drs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_ARRIVAL    = 1'b0;
    localparam logic OP_COMPLETION = 1'b1;

    localparam logic POLICY_FCFS = 1'b0;
    localparam logic POLICY_SSTF = 1'b1;

    typedef struct packed {
        logic [15:0] rid;
        logic [30:0] arrival_time;
        logic [15:0] cylinder;
        logic [31:0] address;
        logic [15:0] pid;
    } entry_t;

    typedef struct packed {
        logic        operation;
        logic [15:0] req_request_id;
        logic [30:0] req_arrival_time;
        logic [15:0] req_cylinder;
        logic [31:0] req_address;
        logic [15:0] req_process_id;
        logic [15:0] head_cylinder;
    } in_item_t;

    typedef struct packed {
        logic [15:0] out_request_id;
        logic [30:0] out_arrival_time;
        logic [15:0] out_cylinder;
        logic [31:0] out_address;
        logic [15:0] out_process_id;
        logic        out_is_null;
        logic        dropped_full;
        logic [4:0]  pending_count;
    } out_item_t;

    // best-so-far record carried from cell to cell in a register during the scan
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [16:0]      seek;
        logic [30:0]      arrival_time;
    } best_t;

    // control from sequencer to every cell
    typedef struct packed {
        logic             push;
        logic [IDX_W-1:0] push_idx;
        logic             remove;
        logic [IDX_W-1:0] remove_idx;
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/disk_request_scheduler.sv */
// ----------------------------------------------------------------------------
// disk_request_scheduler: FCFS / SSTF disk request scheduler
// One request in service plus an ordered queue of pending requests.
// ----------------------------------------------------------------------------
// An arrival's result is valid in the cycle after acceptance. A completion
// with requests pending scans all queue cells one per cycle, carrying the
// best candidate in a register, then shifts the cells down and loads the
// picked entry into the service slot as its result. One item is in work at
// a time; the result sits in an output register, and the next item is
// taken the cycle after that result has been accepted.
`default_nettype none

module disk_request_scheduler
    import drs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic      cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_PICK  = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic             policy_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             cur_valid_reg, cur_valid_next;
    entry_t           cur_reg, cur_next;
    logic             dropped_reg, dropped_next;
    logic [IDX_W-1:0] scan_reg, scan_next;
    best_t            best_reg, best_next;
    logic [15:0]      head_reg;
    cell_ctrl_t       ctrl;
    entry_t           push_entry;
    entry_t           cells [QUEUE_DEPTH];
    best_t            cell_best [QUEUE_DEPTH];
    best_t            best_init;
    logic             in_acc;

    assign in_acc    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = (state_reg == ST_OUT);

    assign push_entry = '{rid: in_data.req_request_id,
                          arrival_time: in_data.req_arrival_time,
                          cylinder: in_data.req_cylinder,
                          address: in_data.req_address,
                          pid: in_data.req_process_id};

    // best record seeded by the first cell, so seek and time start at max
    assign best_init = '{idx: '0, seek: '1, arrival_time: '1};

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            drs_cell u_cell (
                .clk         (clk),
                .my_idx      (IDX_W'(g)),
                .ctrl        (ctrl),
                .push_entry  (push_entry),
                .upper_entry (cells[(g + 1) % QUEUE_DEPTH]),
                .policy      (policy_reg),
                .head        (head_reg),
                .active      (state_reg == ST_SCAN && scan_reg == IDX_W'(g)
                              && CNT_W'(g) < count_reg),
                .best_in     ((g == 0) ? best_init : best_reg),
                .best_out    (cell_best[g]),
                .entry       (cells[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        dropped_next   = dropped_reg;
        scan_next      = scan_reg;
        best_next      = best_reg;
        ctrl           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    dropped_next = 1'b0;
                    scan_next    = '0;
                    state_next   = ST_OUT;
                    if (in_data.operation == OP_ARRIVAL)
                    begin
                        if (!cur_valid_reg)
                        begin
                            cur_next       = push_entry;
                            cur_valid_next = 1'b1;
                        end
                        else if (count_reg == CNT_W'(QUEUE_DEPTH))
                        begin
                            dropped_next = 1'b1;
                        end
                        else
                        begin
                            ctrl.push     = 1'b1;
                            ctrl.push_idx = count_reg[IDX_W-1:0];
                            count_next    = count_reg + 1'b1;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        cur_valid_next = 1'b0;
                        cur_next       = '0;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                best_next = cell_best[scan_reg];
                scan_next = scan_reg + 1'b1;
                if (scan_reg == IDX_W'(QUEUE_DEPTH - 1))
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                cur_next        = cells[best_reg.idx];
                cur_valid_next  = 1'b1;
                ctrl.remove     = 1'b1;
                ctrl.remove_idx = best_reg.idx;
                count_next      = count_reg - 1'b1;
                state_next      = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            policy_reg    <= POLICY_SSTF;
            count_reg     <= '0;
            cur_valid_reg <= 1'b0;
            cur_reg       <= '0;
            dropped_reg   <= 1'b0;
            scan_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cur_valid_reg <= cur_valid_next;
            cur_reg       <= cur_next;
            dropped_reg   <= dropped_next;
            scan_reg      <= scan_next;
            if (cfg_valid && cfg_ready)
            begin
                policy_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        if (in_acc)
        begin
            head_reg <= in_data.head_cylinder;
        end
    end

    always_comb
    begin
        out_data.out_request_id   = cur_reg.rid;
        out_data.out_arrival_time = cur_reg.arrival_time;
        out_data.out_cylinder     = cur_reg.cylinder;
        out_data.out_address      = cur_reg.address;
        out_data.out_process_id   = cur_reg.pid;
        out_data.out_is_null      = !cur_valid_reg;
        out_data.dropped_full     = dropped_reg;
        out_data.pending_count    = 5'(count_reg);
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PICK |-> CNT_W'(best_reg.idx) < count_reg)
        else $error("picked entry beyond queue fill");

    a_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !cur_valid_reg |-> cur_reg == '0)
        else $error("idle service slot not cleared");

    a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dropped_reg) |-> count_reg == CNT_W'(QUEUE_DEPTH))
        else $error("drop reported with room in queue");

endmodule

`default_nettype wire

/* rtl/core/drs_cell.sv */
// ----------------------------------------------------------------------------
// drs_cell: one queue slot
// Holds one entry, compares it against the best record handed in by the
// scheduler and shifts down from its upper neighbor on removal.
// ----------------------------------------------------------------------------
`default_nettype none

module drs_cell
    import drs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic [IDX_W-1:0] my_idx,
    input  wire cell_ctrl_t       ctrl,
    input  wire entry_t           push_entry,
    input  wire entry_t           upper_entry,
    input  wire logic             policy,
    input  wire logic [15:0]      head,
    input  wire logic             active,
    input  wire best_t            best_in,
    output best_t                 best_out,
    output entry_t                entry
);

    entry_t      entry_reg;
    logic [16:0] seek;
    logic        better;

    always_ff @(posedge clk)
    begin
        if (ctrl.push && ctrl.push_idx == my_idx)
        begin
            entry_reg <= push_entry;
        end
        else if (ctrl.remove && my_idx >= ctrl.remove_idx)
        begin
            entry_reg <= upper_entry;
        end
    end

    always_comb
    begin
        seek = (head >= entry_reg.cylinder) ? {1'b0, head - entry_reg.cylinder}
                                            : {1'b0, entry_reg.cylinder - head};
        if (policy == POLICY_FCFS)
        begin
            seek = '0;
        end
        better = (seek < best_in.seek) ||
                 (seek == best_in.seek && entry_reg.arrival_time < best_in.arrival_time);
        best_out = best_in;
        // the first slot always starts the search
        if (active && (better || my_idx == '0))
        begin
            best_out.idx          = my_idx;
            best_out.seek         = seek;
            best_out.arrival_time = entry_reg.arrival_time;
        end
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire
